>>> rtl/malsp_pkg.sv
`timescale 1ns / 1ps

package malsp_pkg;

  localparam int MAX_LINE_DEFAULT = 4096;
  localparam int CHAR_W = 16;
  localparam int POS_W = 12;
  localparam int LEN_W = 13;

  localparam logic [CHAR_W-1:0] CH_NUL    = 16'd0;
  localparam logic [CHAR_W-1:0] CH_TAB    = 16'd9;
  localparam logic [CHAR_W-1:0] CH_LF     = 16'd10;
  localparam logic [CHAR_W-1:0] CH_CR     = 16'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 16'd32;
  localparam logic [CHAR_W-1:0] CH_DQUOTE = 16'd34;
  localparam logic [CHAR_W-1:0] CH_SQUOTE = 16'd39;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 16'd40;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 16'd41;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 16'd44;
  localparam logic [CHAR_W-1:0] CH_LANGLE = 16'd60;
  localparam logic [CHAR_W-1:0] CH_RANGLE = 16'd62;

  typedef enum logic [1:0] {
    KIND_SPAN = 2'd0,
    KIND_OK   = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              end_of_line;
  } char_t;

  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] addr_start;
    logic [LEN_W-1:0] addr_length;
    logic [POS_W-1:0] name_start;
    logic [LEN_W-1:0] name_length;
    logic             last_of_run;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

>>> rtl/mail_address_list_span_parser_top.sv
`timescale 1ns / 1ps

// Parses one header line, one 16-bit character per transfer, into address and name spans; a
// character can be taken every cycle while char_stall is low, and each produces up to two results
// (a span pair and, on the last character of the line, an ok or error status) that are registered
// into a four-entry result queue; char_stall rises while fewer than two queue slots are free, so one
// character per cycle is sustained as long as the result side keeps up, and a character that ends an
// entry on the last position of the line pushes two results and can briefly raise char_stall.
module mail_address_list_span_parser_top
  import malsp_pkg::*;
#(
  parameter int MaxLine = MAX_LINE_DEFAULT
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    char_valid,
  output logic    char_stall,
  input  char_t   char_item,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_item
);

  logic  accept;
  push_t push;

  assign accept = char_valid && !char_stall;

  malsp_parse #(
    .MaxLine(MaxLine)
  ) u_parse (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (char_item),
    .push   (push)
  );

  malsp_queue u_queue (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .stall        (char_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

endmodule

>>> rtl/malsp_parse.sv
`timescale 1ns / 1ps

module malsp_parse
  import malsp_pkg::*;
#(
  parameter int MaxLine = MAX_LINE_DEFAULT
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  accept,
  input  char_t item,
  output push_t push
);

  localparam int PosW = $clog2(MaxLine + 1);
  localparam logic [PosW-1:0] PosMax = PosW'(MaxLine);

  typedef enum logic [3:0] {
    PH_BETWEEN,
    PH_ANGLE,
    PH_QNAME,
    PH_QSEEK,
    PH_QADDR,
    PH_WORD,
    PH_BLANKS,
    PH_PAREN,
    PH_NAMESEEK,
    PH_NADDR,
    PH_OVER
  } phase_t;

  phase_t phase, phase_next, cur_phase;
  logic [PosW-1:0] position, position_next;
  logic [PosW-1:0] word_start, word_start_next;
  logic [PosW-1:0] word_end, word_end_next;
  logic [PosW-1:0] name_begin, name_begin_next;
  logic [PosW-1:0] name_last, name_last_next;
  logic [PosW-1:0] angle_start, angle_start_next;
  logic            closing_quote, closing_quote_next;

  logic [CHAR_W-1:0] c;
  logic              eol;
  logic              over;
  logic              ws;
  logic [PosW-1:0]   p1;
  logic [PosW-1:0]   tr_begin, tr_last;
  logic              emit;
  logic [PosW-1:0]   sp_as, sp_ae, sp_ns, sp_ne;
  logic [PosW-1:0]   al, nl;
  kind_t             status_kind;
  result_t           span_res, status_res;

  always_comb begin
    c = item.character;
    eol = item.end_of_line;
    over = (position >= PosMax);
    p1 = position + 1'b1;
    cur_phase = over ? PH_OVER : phase;
    ws = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

    // Name tracking: a non-blank character extends the trimmed name.
    tr_begin = (name_last == '0) ? position : name_begin;
    tr_last = p1;
    if (ws) begin
      tr_begin = name_begin;
      tr_last = name_last;
    end

    phase_next = cur_phase;
    position_next = over ? position : p1;
    word_start_next = word_start;
    word_end_next = word_end;
    name_begin_next = name_begin;
    name_last_next = name_last;
    angle_start_next = angle_start;
    closing_quote_next = closing_quote;

    emit = 1'b0;
    sp_as = '0;
    sp_ae = '0;
    sp_ns = '0;
    sp_ne = '0;

    case (cur_phase)
      PH_BETWEEN: begin
        if (c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_COMMA, CH_NUL}) begin
          phase_next = PH_BETWEEN;
        end else if (c == CH_LANGLE) begin
          angle_start_next = p1;
          phase_next = PH_ANGLE;
        end else if (c inside {CH_SQUOTE, CH_DQUOTE}) begin
          closing_quote_next = (c == CH_SQUOTE);
          name_begin_next = p1;
          phase_next = PH_QNAME;
        end else begin
          word_start_next = position;
          // The name restarts here: empty on a blank, else with this character.
          if (ws) begin
            name_last_next = '0;
          end else begin
            name_begin_next = position;
            name_last_next = p1;
          end
          if (eol) begin
            emit = 1'b1;
            sp_as = position;
            sp_ae = p1;
          end else begin
            phase_next = PH_WORD;
          end
        end
      end
      PH_WORD: begin
        if (c inside {CH_SPACE, CH_TAB, CH_COMMA, CH_LF}) begin
          word_end_next = position;
          if ((c == CH_COMMA) || (c == CH_LF) || eol) begin
            emit = 1'b1;
            sp_as = word_start;
            sp_ae = position;
            phase_next = PH_BETWEEN;
          end else begin
            phase_next = PH_BLANKS;
          end
        end else begin
          name_begin_next = tr_begin;
          name_last_next = tr_last;
          if (eol) begin
            emit = 1'b1;
            sp_as = word_start;
            sp_ae = p1;
            phase_next = PH_BETWEEN;
          end
        end
      end
      PH_BLANKS: begin
        if (c inside {CH_SPACE, CH_TAB}) begin
          phase_next = PH_BLANKS;
        end else if (c == CH_LANGLE) begin
          angle_start_next = p1;
          phase_next = PH_NADDR;
        end else if (c == CH_LPAREN) begin
          name_begin_next = p1;
          phase_next = PH_PAREN;
        end else begin
          name_begin_next = tr_begin;
          name_last_next = tr_last;
          phase_next = PH_NAMESEEK;
        end
      end
      PH_NAMESEEK: begin
        if (c == CH_LANGLE) begin
          angle_start_next = p1;
          phase_next = PH_NADDR;
        end else begin
          name_begin_next = tr_begin;
          name_last_next = tr_last;
        end
      end
      PH_NADDR, PH_QADDR: begin
        if (c == CH_RANGLE) begin
          emit = 1'b1;
          sp_as = angle_start;
          sp_ae = position;
          sp_ns = name_begin;
          sp_ne = name_last;
          phase_next = PH_BETWEEN;
        end
      end
      PH_PAREN: begin
        if (c == CH_RPAREN) begin
          emit = 1'b1;
          sp_as = word_start;
          sp_ae = word_end;
          sp_ns = name_begin;
          sp_ne = position;
          phase_next = PH_BETWEEN;
        end
      end
      PH_ANGLE: begin
        if (c == CH_RANGLE) begin
          emit = 1'b1;
          sp_as = angle_start;
          sp_ae = position;
          phase_next = PH_BETWEEN;
        end
      end
      PH_QNAME: begin
        if (c == (closing_quote ? CH_SQUOTE : CH_DQUOTE)) begin
          name_last_next = position;
          phase_next = PH_QSEEK;
        end
      end
      PH_QSEEK: begin
        if (c == CH_LANGLE) begin
          angle_start_next = p1;
          phase_next = PH_QADDR;
        end
      end
      default: begin
        phase_next = PH_OVER;
      end
    endcase

    status_kind = (phase_next == PH_BETWEEN) ? KIND_OK : KIND_ERR;

    // Every line end returns the parser to its reset condition.
    if (eol) begin
      phase_next = PH_BETWEEN;
      position_next = '0;
      word_start_next = '0;
      word_end_next = '0;
      name_begin_next = '0;
      name_last_next = '0;
      angle_start_next = '0;
      closing_quote_next = 1'b0;
    end

    al = (sp_ae >= sp_as) ? sp_ae - sp_as : '0;
    nl = (sp_ne > sp_ns) ? sp_ne - sp_ns : '0;

    span_res.kind = KIND_SPAN;
    span_res.addr_start = POS_W'(sp_as);
    span_res.addr_length = LEN_W'(al);
    span_res.name_start = (nl == '0) ? '0 : POS_W'(sp_ns);
    span_res.name_length = LEN_W'(nl);
    span_res.last_of_run = !eol;

    status_res = '0;
    status_res.kind = status_kind;
    status_res.last_of_run = 1'b1;

    push.count = '0;
    if (accept) begin
      push.count = 2'({1'b0, emit} + {1'b0, eol});
    end
    push.first = emit ? span_res : status_res;
    push.second = status_res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_BETWEEN;
      position <= '0;
      word_start <= '0;
      word_end <= '0;
      name_begin <= '0;
      name_last <= '0;
      angle_start <= '0;
      closing_quote <= 1'b0;
    end else if (accept) begin
      phase <= phase_next;
      position <= position_next;
      word_start <= word_start_next;
      word_end <= word_end_next;
      name_begin <= name_begin_next;
      name_last <= name_last_next;
      angle_start <= angle_start_next;
      closing_quote <= closing_quote_next;
    end
  end

`ifndef SYNTH
  a_eol_resets: assert property (@(posedge clk) disable iff (rst)
    accept && item.end_of_line |=> position == '0 && phase == PH_BETWEEN)
    else $error("line end did not return the parser to its initial state");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    position <= PosMax)
    else $error("position ran past the line limit");

  a_two_results: assert property (@(posedge clk) disable iff (rst)
    push.count == 2'd2 |-> push.first.kind == KIND_SPAN && push.second.kind != KIND_SPAN)
    else $error("a double transfer must be a span followed by a status");
`endif

endmodule

>>> rtl/malsp_queue.sv
`timescale 1ns / 1ps

module malsp_queue
  import malsp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    stall,
  output logic    result_valid,
  input  logic    result_stall,
  output result_t result_item
);

  localparam int Depth = 4;
  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  result_t mem [Depth];
  logic [PtrW-1:0] wr_ptr, wr_ptr_1, rd_ptr;
  logic [CntW-1:0] count, count_next;
  logic            pop;

  assign pop = result_valid && !result_stall;
  assign result_valid = (count != '0);
  assign result_item = mem[rd_ptr];
  assign wr_ptr_1 = wr_ptr + 1'b1;
  assign stall = (count > CntW'(Depth - 2));
  assign count_next = count + CntW'(push.count) - CntW'(pop);

  always_ff @(posedge clk) begin
    for (int i = 0; i < Depth; i++) begin
      if ((push.count != 2'd0) && (wr_ptr == PtrW'(i))) begin
        mem[i] <= push.first;
      end
      if ((push.count == 2'd2) && (wr_ptr_1 == PtrW'(i))) begin
        mem[i] <= push.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      wr_ptr <= wr_ptr + PtrW'(push.count);
      rd_ptr <= rd_ptr + PtrW'(pop);
      count <= count_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("result queue overflow");

  a_no_push_when_stalled: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> !stall)
    else $error("results pushed while the character side was stalled");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    pop && push.count == 2'd0 |=> count == $past(count) - 1'b1)
    else $error("queue count did not follow a lone transfer out");
`endif

endmodule
